// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros for the rtl, included by noise_burst_click_synth.sv
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising clock, off while reset is low
`define NBCS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("nbcs assertion failed");

// same-cycle implication
`define NBCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  `NBCS_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// next-cycle implication
`define NBCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  `NBCS_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

// ----- hw/rtl/nbcs_pkg.sv -----
// ---------------------------------------------------------------------------
// nbcs_pkg
// widths, register indexes, reset values and multiplier types of the
// noise burst synthesizer
// ---------------------------------------------------------------------------
package nbcs_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SEED      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DECAY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DECAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_START    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LEVEL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_COEFF = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LENGTH     = 3'd7;

  // field and state widths
  localparam int SEED_W   = 32;
  localparam int COEF_W   = 16;
  localparam int POS_W    = 13;
  localparam int LEN_W    = 14;
  localparam int ENV_W    = 17;
  localparam int FILT_W   = 24;
  localparam int SAMPLE_W = 16;

  // noise value: 14 generator bits, offset to signed, times eight
  localparam int NOISE_LSB = 9;
  localparam int NOISE_MSB = 22;
  localparam int NOISE_PAD = 3;
  localparam int NOISE_W   = NOISE_MSB - NOISE_LSB + 1 + NOISE_PAD;

  // fixed point shifts
  localparam int Q16_SHIFT  = 16;
  localparam int X_SHIFT    = 12;
  localparam int GAIN_SHIFT = 20;

  localparam int MAX_CLIP_SAMPLES = 8192;
  localparam int SAMPLE_LIMIT     = 32767;

  localparam logic [SEED_W-1:0] LCG_MUL = 32'd1664525;
  localparam logic [SEED_W-1:0] LCG_ADD = 32'd1013904223;
  localparam logic [ENV_W-1:0]  ENV_ONE = 17'h10000;

  // register reset values
  localparam logic [SEED_W-1:0] RST_NOISE_SEED      = 32'h9E3779B9;
  localparam logic [COEF_W-1:0] RST_FIRST_DECAY     = 16'd65328;
  localparam logic [COEF_W-1:0] RST_SECOND_DECAY    = 16'd65358;
  localparam logic [POS_W-1:0]  RST_SECOND_START    = 13'd2426;
  localparam logic [COEF_W-1:0] RST_SECOND_LEVEL    = 16'd45875;
  localparam logic [COEF_W-1:0] RST_SMOOTHING_COEFF = 16'd29491;
  localparam logic [COEF_W-1:0] RST_OUTPUT_GAIN     = 16'd22000;
  localparam logic [LEN_W-1:0]  RST_CLIP_LENGTH     = 14'd6174;

  // digit serial multiplier: signed a times unsigned b, 4 bits of b a cycle
  localparam int MUL_A_W     = 26;
  localparam int MUL_B_W     = 32;
  localparam int MUL_DIGIT_W = 4;
  localparam int MUL_STEPS   = MUL_B_W / MUL_DIGIT_W;
  localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
  localparam int MUL_H_W     = MUL_A_W + MUL_DIGIT_W + 1;
  localparam int MUL_P_W     = MUL_H_W + MUL_B_W;

  typedef struct packed {
    logic                      start;
    logic signed [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0]        b;
  } mul_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [MUL_P_W-1:0] prod;
  } mul_rsp_t;

endpackage

// ----- hw/rtl/nbcs_mul.sv -----
// ---------------------------------------------------------------------------
// nbcs_mul
// digit serial multiplier, one 4-bit digit of the unsigned operand a cycle,
// partial sums shifted right through a high/low product register
// ---------------------------------------------------------------------------
module nbcs_mul import nbcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic signed [MUL_A_W-1:0] a_q, a_d;
  logic signed [MUL_H_W-1:0] h_q, h_d;
  logic [MUL_B_W-1:0]        l_q, l_d;
  logic [MUL_CNT_W-1:0]      cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic signed [MUL_H_W-1:0] pp;
  logic [MUL_H_W:0]          sum;

  always_comb begin
    // a times the low digit of b, digit taken as unsigned
    pp  = a_q * $signed({1'b0, l_q[MUL_DIGIT_W-1:0]});
    sum = {h_q[MUL_H_W-1], h_q} + {pp[MUL_H_W-1], pp};

    a_d    = a_q;
    h_d    = h_q;
    l_d    = l_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (req_i.start) begin
      a_d    = req_i.a;
      h_d    = '0;
      l_d    = req_i.b;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // arithmetic shift of the running sum, low digit into the product
      h_d   = {{(MUL_DIGIT_W-1){sum[MUL_H_W]}}, sum[MUL_H_W:MUL_DIGIT_W]};
      l_d   = {sum[MUL_DIGIT_W-1:0], l_q[MUL_B_W-1:MUL_DIGIT_W]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    h_q <= h_d;
    l_q <= l_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = $signed({h_q, l_q});

endmodule

// ----- hw/rtl/noise_burst_click_synth.sv -----
// ---------------------------------------------------------------------------
// noise_burst_click_synth: decaying noise burst sample generator
// six products per request on the 4-bit serial multiplier while the clip plays
// and none once finished; requests stall until the output reg takes the result
// reset loads register defaults and a fresh clip at sample zero, no clear pass
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module noise_burst_click_synth import nbcs_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  // request side
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       restart_i,
  // result side
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_o,
  output logic [POS_W-1:0]           sample_index_o,
  output logic                       last_o,
  output logic                       finished_o
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GO   = 2'd1;  // issue one product
  localparam logic [1:0] ST_WAIT = 2'd2;  // wait for it, then write back
  localparam logic [1:0] ST_OUT  = 2'd3;  // hand the result to the output reg

  // products in issue order; the envelopes decay after the sample is formed
  localparam logic [2:0] OP_LCG  = 3'd0;  // generator step
  localparam logic [2:0] OP_X    = 3'd1;  // noise times envelope sum
  localparam logic [2:0] OP_FILT = 3'd2;  // low-pass step
  localparam logic [2:0] OP_GAIN = 3'd3;  // output gain
  localparam logic [2:0] OP_ENV1 = 3'd4;  // first envelope decay
  localparam logic [2:0] OP_ENV2 = 3'd5;  // second envelope decay

  localparam int GP_W = FILT_W + COEF_W;    // gain product width
  localparam int GQ_W = GP_W - GAIN_SHIFT;  // gain quotient width

  // configuration registers
  logic [SEED_W-1:0] seed_q;
  logic [COEF_W-1:0] decay1_q;
  logic [COEF_W-1:0] decay2_q;
  logic [POS_W-1:0]  start2_q;
  logic [COEF_W-1:0] level2_q;
  logic [COEF_W-1:0] smooth_q;
  logic [COEF_W-1:0] gain_q;
  logic [LEN_W-1:0]  clip_len_q;

  // clip state
  logic [SEED_W-1:0]        noise_q;
  logic [POS_W-1:0]         pos_q;
  logic [ENV_W-1:0]         env1_q;
  logic [ENV_W-1:0]         env2_q;
  logic signed [FILT_W-1:0] fs_q;
  logic                     done_q;

  // sequencer
  logic [1:0] state_q, state_d;
  logic [2:0] op_q, op_d;

  // intermediate and result registers
  logic signed [FILT_W-1:0]   x_q;
  logic signed [SAMPLE_W-1:0] res_sample_q;
  logic [POS_W-1:0]           res_index_q;
  logic                       res_last_q;
  logic                       res_fin_q;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [POS_W-1:0]           index_q;
  logic                       last_q;
  logic                       fin_q;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic                       cfg_we;
  logic                       accept;
  logic                       wb;
  logic                       out_load;
  logic signed [NOISE_W-1:0]  noise_val;
  logic [ENV_W-1:0]           env_sum;
  logic signed [FILT_W:0]     filt_diff;
  logic [LEN_W-1:0]           eff_len;
  logic                       is_last;
  logic [GP_W-1:0]            gain_prod;
  logic [GP_W-1:0]            gain_biased;
  logic signed [GQ_W-1:0]     gain_quot;
  logic signed [SAMPLE_W-1:0] gain_sat;

  // ---------------------------------------------------------------------
  // configuration port, always ready, unguarded; user writes only between requests
  // ---------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q     <= RST_NOISE_SEED;
      decay1_q   <= RST_FIRST_DECAY;
      decay2_q   <= RST_SECOND_DECAY;
      start2_q   <= RST_SECOND_START;
      level2_q   <= RST_SECOND_LEVEL;
      smooth_q   <= RST_SMOOTHING_COEFF;
      gain_q     <= RST_OUTPUT_GAIN;
      clip_len_q <= RST_CLIP_LENGTH;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_NOISE_SEED:      seed_q     <= cfg_data_i[SEED_W-1:0];
        CFG_FIRST_DECAY:     decay1_q   <= cfg_data_i[COEF_W-1:0];
        CFG_SECOND_DECAY:    decay2_q   <= cfg_data_i[COEF_W-1:0];
        CFG_SECOND_START:    start2_q   <= cfg_data_i[POS_W-1:0];
        CFG_SECOND_LEVEL:    level2_q   <= cfg_data_i[COEF_W-1:0];
        CFG_SMOOTHING_COEFF: smooth_q   <= cfg_data_i[COEF_W-1:0];
        CFG_OUTPUT_GAIN:     gain_q     <= cfg_data_i[COEF_W-1:0];
        CFG_CLIP_LENGTH:     clip_len_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign wb         = (state_q == ST_WAIT) & mul_rsp.done;
  // output reg takes the result when empty or being drained this cycle
  assign out_load   = (state_q == ST_OUT) & (~out_valid_q | ~out_stall_i);

  // ---------------------------------------------------------------------
  // datapath helpers
  // ---------------------------------------------------------------------
  always_comb begin
    // 14 generator bits minus 8192, scaled by eight: flip the top bit
    noise_val = {~noise_q[NOISE_MSB], noise_q[NOISE_MSB-1:NOISE_LSB], {NOISE_PAD{1'b0}}};

    // second envelope at most 65535, first at most one: sum fits 17 bits
    env_sum   = env1_q + env2_q;
    filt_diff = {x_q[FILT_W-1], x_q} - {fs_q[FILT_W-1], fs_q};

    // zero length acts as one sample, long clips clamp to the maximum
    if (clip_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (clip_len_q > LEN_W'(MAX_CLIP_SAMPLES)) begin
      eff_len = LEN_W'(MAX_CLIP_SAMPLES);
    end else begin
      eff_len = clip_len_q;
    end
    is_last = (({1'b0, pos_q} + LEN_W'(1)) >= eff_len);

    // gain product: truncate toward zero by biasing negatives, then clamp
    gain_prod   = mul_rsp.prod[GP_W-1:0];
    gain_biased = gain_prod + GP_W'({GAIN_SHIFT{gain_prod[GP_W-1]}});
    gain_quot   = $signed(gain_biased[GP_W-1:GAIN_SHIFT]);
    if (gain_quot > $signed(GQ_W'(SAMPLE_LIMIT))) begin
      gain_sat = SAMPLE_W'(SAMPLE_LIMIT);
    end else if (gain_quot < -$signed(GQ_W'(SAMPLE_LIMIT))) begin
      gain_sat = SAMPLE_W'(-SAMPLE_LIMIT);
    end else begin
      gain_sat = gain_quot[SAMPLE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // operand select for the shared multiplier
  // ---------------------------------------------------------------------
  always_comb begin
    mul_req.start = (state_q == ST_GO);
    mul_req.a     = '0;
    mul_req.b     = '0;
    unique case (op_q)
      OP_LCG: begin
        mul_req.a = MUL_A_W'(LCG_MUL);
        mul_req.b = noise_q;
      end
      OP_X: begin
        mul_req.a = MUL_A_W'(noise_val);
        mul_req.b = MUL_B_W'(env_sum);
      end
      OP_FILT: begin
        mul_req.a = MUL_A_W'(filt_diff);
        mul_req.b = MUL_B_W'(smooth_q);
      end
      OP_GAIN: begin
        mul_req.a = MUL_A_W'(fs_q);
        mul_req.b = MUL_B_W'(gain_q);
      end
      OP_ENV1: begin
        mul_req.a = MUL_A_W'(env1_q);
        mul_req.b = MUL_B_W'(decay1_q);
      end
      OP_ENV2: begin
        mul_req.a = MUL_A_W'(env2_q);
        mul_req.b = MUL_B_W'(decay2_q);
      end
      default: ;
    endcase
  end

  nbcs_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // ---------------------------------------------------------------------
  // sequencer: a request on a finished clip without restart goes straight to output,
  // otherwise the six products run one after another
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d    = OP_LCG;
          state_d = (restart_i || !done_q) ? ST_GO : ST_OUT;
        end
      end
      ST_GO: state_d = ST_WAIT;
      ST_WAIT: begin
        if (mul_rsp.done) begin
          op_d    = op_q + 1'b1;
          state_d = (op_q == OP_ENV2) ? ST_OUT : ST_GO;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_LCG;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // ---------------------------------------------------------------------
  // clip state: restart clears at accept, products write back in turn
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q <= RST_NOISE_SEED;
      pos_q   <= '0;
      env1_q  <= ENV_ONE;
      env2_q  <= '0;
      fs_q    <= '0;
      done_q  <= 1'b0;
    end else if (accept) begin
      if (restart_i) begin
        noise_q <= seed_q;
        pos_q   <= '0;
        env1_q  <= ENV_ONE;
        env2_q  <= '0;
        fs_q    <= '0;
        done_q  <= 1'b0;
      end
    end else if (wb) begin
      unique case (op_q)
        OP_LCG: begin
          noise_q <= mul_rsp.prod[SEED_W-1:0] + LCG_ADD;
          // second burst loads before the envelopes are summed
          if (pos_q == start2_q) begin
            env2_q <= ENV_W'(level2_q);
          end
        end
        OP_FILT: fs_q <= fs_q + mul_rsp.prod[Q16_SHIFT+FILT_W-1:Q16_SHIFT];
        OP_ENV1: env1_q <= mul_rsp.prod[Q16_SHIFT+ENV_W-1:Q16_SHIFT];
        OP_ENV2: begin
          env2_q <= mul_rsp.prod[Q16_SHIFT+ENV_W-1:Q16_SHIFT];
          pos_q  <= pos_q + 1'b1;
          if (is_last) begin
            done_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // filtered input and pending result
  always_ff @(posedge clk_i) begin
    if (accept && !restart_i && done_q) begin
      // silence once the clip is over
      res_sample_q <= '0;
      res_index_q  <= '0;
      res_last_q   <= 1'b0;
      res_fin_q    <= 1'b1;
    end else if (wb) begin
      unique case (op_q)
        OP_X: x_q <= mul_rsp.prod[X_SHIFT+FILT_W-1:X_SHIFT];
        OP_GAIN: begin
          res_sample_q <= gain_sat;
          res_index_q  <= pos_q;
          res_last_q   <= is_last;
          res_fin_q    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // output register, decouples the result side from the sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_q <= res_sample_q;
      index_q  <= res_index_q;
      last_q   <= res_last_q;
      fin_q    <= res_fin_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_o       = sample_q;
  assign sample_index_o = index_q;
  assign last_o         = last_q;
  assign finished_o     = fin_q;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  // a product only completes while the sequencer waits for it
  `NBCS_ASSERT_IMPL(a_done_in_wait, clk_i, rst_ni, mul_rsp.done, state_q == ST_WAIT)
  // the serial product never returns the cycle after issue
  `NBCS_ASSERT_NEXT(a_no_early_done, clk_i, rst_ni, state_q == ST_GO, !mul_rsp.done)
  // a request on a finished clip without restart yields a silent result
  `NBCS_ASSERT_NEXT(a_fin_result, clk_i, rst_ni, accept && !restart_i && done_q, res_fin_q)
  // a finished result carries silence and no last flag
  `NBCS_ASSERT_IMPL(a_fin_silent, clk_i, rst_ni, out_valid_o && finished_o,
                    sample_o == '0 && !last_o)

endmodule

// ----- tb/sv/nbcs_sample_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// nbcs_sample_checker
// tracks register writes and accepted requests, keeps its own copy of the
// synthesizer state, queues the sample each request should produce and
// compares every accepted sample against the oldest queued one
// ---------------------------------------------------------------------------
module nbcs_sample_checker import nbcs_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic                       restart_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [POS_W-1:0]           sample_index_i,
  input  logic                       last_i,
  input  logic                       finished_i,
  output int unsigned                mismatch_cnt_o,
  output int unsigned                pending_o
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]           index;
    logic                       last;
    logic                       finished;
  } sample_t;

  // register copies
  logic [SEED_W-1:0] seed_r;
  logic [COEF_W-1:0] first_decay_r;
  logic [COEF_W-1:0] second_decay_r;
  logic [POS_W-1:0]  second_start_r;
  logic [COEF_W-1:0] second_level_r;
  logic [COEF_W-1:0] smooth_r;
  logic [COEF_W-1:0] gain_r;
  logic [LEN_W-1:0]  clip_len_r;

  // synthesizer state
  logic [SEED_W-1:0] lcg_r;
  int unsigned       pos_r;
  longint            env1_r;
  longint            env2_r;
  longint            filt_r;
  logic              done_r;

  sample_t     expected_samples[$];
  sample_t     head;
  int unsigned mismatches;

  function automatic void restart_clip();
    lcg_r  = seed_r;
    pos_r  = 0;
    env1_r = longint'(ENV_ONE);
    env2_r = 0;
    filt_r = 0;
    done_r = 1'b0;
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_NOISE_SEED:      seed_r         = data[SEED_W-1:0];
      CFG_FIRST_DECAY:     first_decay_r  = data[COEF_W-1:0];
      CFG_SECOND_DECAY:    second_decay_r = data[COEF_W-1:0];
      CFG_SECOND_START:    second_start_r = data[POS_W-1:0];
      CFG_SECOND_LEVEL:    second_level_r = data[COEF_W-1:0];
      CFG_SMOOTHING_COEFF: smooth_r       = data[COEF_W-1:0];
      CFG_OUTPUT_GAIN:     gain_r         = data[COEF_W-1:0];
      CFG_CLIP_LENGTH:     clip_len_r     = data[LEN_W-1:0];
      default: ;
    endcase
  endfunction

  // one step of the synthesizer: advances the state, returns the sample
  function automatic sample_t synth_next_sample(input logic restart);
    sample_t          r;
    logic [13:0]      noise_bits;
    longint           noise;
    longint           x;
    longint           prod;
    longint           mag;
    longint           v;
    logic             neg;
    int unsigned      len;
    r = '0;
    if (restart) restart_clip();
    if (done_r) begin
      r.finished = 1'b1;
      return r;
    end
    lcg_r = lcg_r * LCG_MUL + LCG_ADD;
    noise_bits = lcg_r[NOISE_MSB:NOISE_LSB];
    noise = (longint'(noise_bits) - 8192) * 8;
    if (pos_r == int'(second_start_r)) env2_r = longint'(second_level_r);
    // arithmetic shifts on signed values floor toward minus infinity
    x = (noise * (env1_r + env2_r)) >>> X_SHIFT;
    filt_r = filt_r + ((longint'(smooth_r) * (x - filt_r)) >>> Q16_SHIFT);
    prod = filt_r * longint'(gain_r);
    neg = (prod < 0);
    mag = (neg ? -prod : prod) >> GAIN_SHIFT;
    if (mag > SAMPLE_LIMIT) mag = longint'(SAMPLE_LIMIT);
    v = neg ? -mag : mag;
    env1_r = (env1_r * longint'(first_decay_r)) >> Q16_SHIFT;
    env2_r = (env2_r * longint'(second_decay_r)) >> Q16_SHIFT;
    len = 32'(clip_len_r);
    if (len == 0) len = 1;
    if (len > MAX_CLIP_SAMPLES) len = MAX_CLIP_SAMPLES;
    r.sample = v[SAMPLE_W-1:0];
    r.index  = pos_r[POS_W-1:0];
    r.last   = (pos_r + 1 >= len);
    pos_r++;
    if (r.last) done_r = 1'b1;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_r         = RST_NOISE_SEED;
      first_decay_r  = RST_FIRST_DECAY;
      second_decay_r = RST_SECOND_DECAY;
      second_start_r = RST_SECOND_START;
      second_level_r = RST_SECOND_LEVEL;
      smooth_r       = RST_SMOOTHING_COEFF;
      gain_r         = RST_OUTPUT_GAIN;
      clip_len_r     = RST_CLIP_LENGTH;
      restart_clip();
      expected_samples.delete();
      mismatches = 0;
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_write(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_i) expected_samples.push_back(synth_next_sample(restart_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          $error("sample %0d at index %0d with no request waiting", sample_i, sample_index_i);
          mismatches++;
        end else begin
          head = expected_samples.pop_front();
          if (sample_i !== head.sample) begin
            $error("sample: expected %0d, actual %0d", head.sample, sample_i);
            mismatches++;
          end
          if (sample_index_i !== head.index) begin
            $error("sample_index: expected %0d, actual %0d", head.index, sample_index_i);
            mismatches++;
          end
          if (last_i !== head.last) begin
            $error("last: expected %0b, actual %0b", head.last, last_i);
            mismatches++;
          end
          if (finished_i !== head.finished) begin
            $error("finished: expected %0b, actual %0b", head.finished, finished_i);
            mismatches++;
          end
        end
      end
      mismatch_cnt_o <= mismatches;
      pending_o      <= expected_samples.size();
    end
  end

endmodule

// ----- tb/sv/noise_burst_click_synth_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// noise_burst_click_synth_tb
// drives sample requests and register writes into the burst synthesizer,
// varies idle gaps and output stalls per phase, and leaves all prediction
// and comparison to the sample checker
// ---------------------------------------------------------------------------
module noise_burst_click_synth_tb import nbcs_pkg::*; ();

  localparam int CLK_PERIOD   = 20;
  localparam int RST_CYCLES   = 3;
  localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
  localparam int DRAIN_CYCLES = 80;       // longer than the latency of one request
  localparam int LIMIT_CYCLES = 400000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 56;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       restart_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_o;
  logic [POS_W-1:0]           sample_index_o;
  logic                       last_o;
  logic                       finished_o;

  int unsigned mismatch_cnt;
  int unsigned pending;
  int unsigned cycle_cnt = 0;

  // idling knobs, percent per cycle
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  // hold-off handoff: main toggles the flag, the receiver process counts
  bit          hold_req = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  noise_burst_click_synth i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_o       (sample_o),
    .sample_index_o (sample_index_o),
    .last_o         (last_o),
    .finished_o     (finished_o)
  );

  nbcs_sample_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .restart_i      (restart_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_i       (sample_o),
    .sample_index_i (sample_index_o),
    .last_i         (last_o),
    .finished_i     (finished_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  // receiver: random stalls, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one register write; valid stays high so writes can go back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // stop requests, let every sample come back, then write all registers
  task automatic load_config(input logic [31:0] seed, input logic [15:0] d1,
                             input logic [15:0] d2, input logic [12:0] start,
                             input logic [15:0] level, input logic [15:0] coeff,
                             input logic [15:0] gain, input logic [13:0] len);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    write_reg(CFG_NOISE_SEED, seed);
    write_reg(CFG_FIRST_DECAY, CFG_DATA_W'(d1));
    write_reg(CFG_SECOND_DECAY, CFG_DATA_W'(d2));
    write_reg(CFG_SECOND_START, CFG_DATA_W'(start));
    write_reg(CFG_SECOND_LEVEL, CFG_DATA_W'(level));
    write_reg(CFG_SMOOTHING_COEFF, CFG_DATA_W'(coeff));
    write_reg(CFG_OUTPUT_GAIN, CFG_DATA_W'(gain));
    write_reg(CFG_CLIP_LENGTH, CFG_DATA_W'(len));
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // one sample request, with random idle cycles ahead of it
  task automatic send_request(input logic restart);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'($urandom_range(1));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // coefficient mix: both extremes, slow decays, anything
  function automatic logic [15:0] pick_coef();
    case ($urandom_range(3))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(65535));
      default: return 16'($urandom_range(60000, 65535));
    endcase
  endfunction

  function automatic logic [13:0] pick_len();
    case ($urandom_range(7))
      0:       return 14'd0;
      1:       return 14'($urandom_range(8192, 16383));
      2:       return 14'($urandom_range(100, 1000));
      default: return 14'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [12:0] pick_start();
    if ($urandom_range(3) == 0) return 13'($urandom_range(8191));
    return 13'($urandom_range(40));
  endfunction

  initial begin
    repeat (RST_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // default registers: clip plays from reset, then a restart mid clip
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);

    // three-sample clip with every gain maxed so the output clips at the rails,
    // then play past the end, restart while finished and while playing
    load_config(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 13'd1, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 14'd3);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);

    // all zero: zero length counts as one, second burst start past the end
    load_config(32'd0, 16'd0, 16'd0, 13'd8191, 16'd0, 16'd0, 16'd0, 14'd0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b1);

    // length above the maximum saturates, second burst at sample zero
    load_config($urandom, 16'hFFFF, 16'd0, 13'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                14'h3FFF);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);

    // random phases cycling through the idling modes
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      load_config($urandom, pick_coef(), pick_coef(), pick_start(), pick_coef(),
                  pick_coef(), pick_coef(), pick_len());
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      send_request($urandom_range(3) != 0);
      for (int k = 1; k < PHASE_ITEMS; k++) begin
        // long receiver hold-off while requests keep coming, fills the block
        if (ph == 2 && k == 15) hold_req = ~hold_req;
        // sender pause until the block has handed back every sample
        if (ph == 5 && k == 20) begin
          in_valid_i <= 1'b0;
          wait (pending == 0);
          @(negedge clk_i);
        end
        send_request($urandom_range(15) == 0);
      end
    end

    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
